@@ rtl/bptc_pkg.sv @@
// Package for the barometric pressure and temperature compensation block.
// Holds the shared widths, constants, register indexes and stage structs.
// No dependencies.
`default_nettype none

package bptc_pkg;

	// Pipeline depth: one register stage per entry
	localparam int NUM_STAGES = 10;

	// Channel and port widths
	localparam int CAL_W      = 16;
	localparam int RAW_W      = 24;
	localparam int PRES_W     = 18;
	localparam int TEMP_OUT_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 40;

	// Temperature thresholds in 0.01 C
	localparam logic signed [18:0] TEMP_REF      = 19'sd2000;
	// Offset from the first-order shift term to (TEMP + 1500)
	localparam logic signed [18:0] COLD_DEEP_OFS = 19'sd3500;

	// Output saturation bounds
	localparam logic [PRES_W-1:0]         PRES_MAX = '1;
	localparam logic signed [19:0]        TEMP_MIN = -20'sd32768;
	localparam logic signed [19:0]        TEMP_MAX = 20'sd32767;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CAL_PRESSURE_SENS   = 3'd0,
		CAL_PRESSURE_OFFSET = 3'd1,
		CAL_SENS_TEMPCO     = 3'd2,
		CAL_OFFSET_TEMPCO   = 3'd3,
		CAL_REF_TEMP        = 3'd4,
		CAL_TEMP_COEFF      = 3'd5
	} cal_idx_t;

	// Calibration words
	typedef struct packed {
		logic [CAL_W-1:0] pressure_sens;
		logic [CAL_W-1:0] pressure_offset;
		logic [CAL_W-1:0] sens_tempco;
		logic [CAL_W-1:0] offset_tempco;
		logic [CAL_W-1:0] ref_temp;
		logic [CAL_W-1:0] temp_coeff;
	} cal_t;

	// First-order results, handed to the correction stages
	typedef struct packed {
		logic [RAW_W-1:0]   d1;
		logic signed [18:0] temp;
		logic signed [34:0] off;
		logic signed [33:0] sens;
		logic [16:0]        t2;
		logic signed [17:0] a;
		logic signed [18:0] b;
		logic               cold;
		logic               colder;
	} fo_t;

	// Corrected values, handed to the pressure stages
	typedef struct packed {
		logic [RAW_W-1:0]   d1;
		logic signed [19:0] temp;
		logic signed [38:0] off;
		logic signed [37:0] sens;
	} so_t;

	// Final result item
	typedef struct packed {
		logic [PRES_W-1:0]            pressure;
		logic signed [TEMP_OUT_W-1:0] temperature;
		logic                         clipped;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/bptc_first_order.sv @@
// First-order compensation stages (stages 1 to 3): dT, products, TEMP/OFF/SENS.
// Depends on bptc_pkg.
`default_nettype none

module bptc_first_order (
	input  wire logic                        clk,
	input  wire logic [2:0]                  en,
	input  wire bptc_pkg::cal_t              cal,
	input  wire logic [bptc_pkg::RAW_W-1:0]  raw_pressure,
	input  wire logic [bptc_pkg::RAW_W-1:0]  raw_temperature,
	output bptc_pkg::fo_t                    fo
);
	import bptc_pkg::*;

	logic [RAW_W-1:0]   d1_s1, d1_s2;
	logic signed [24:0] dt_s1;

	logic signed [40:0] prod_temp_s2, prod_off_s2, prod_sens_s2;
	logic signed [49:0] prod_sq_s2;
	logic signed [40:0] prod_temp_c, prod_off_c, prod_sens_c;
	logic signed [49:0] prod_sq_c;

	logic signed [17:0] a_c;
	logic signed [18:0] temp_c, b_c;
	logic signed [34:0] off_c;
	logic signed [33:0] sens_c;
	fo_t                fo_s3;

	// Stage 1: difference to the reference temperature
	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ref_temp, 8'h00});
		end
	end

	// Stage 2: the four products on dT
	always_comb begin
		prod_temp_c = 41'(dt_s1) * 41'($signed({1'b0, cal.temp_coeff}));
		prod_off_c  = 41'(dt_s1) * 41'($signed({1'b0, cal.offset_tempco}));
		prod_sens_c = 41'(dt_s1) * 41'($signed({1'b0, cal.sens_tempco}));
		prod_sq_c   = 50'(dt_s1) * 50'(dt_s1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d1_s2        <= d1_s1;
			prod_temp_s2 <= prod_temp_c;
			prod_off_s2  <= prod_off_c;
			prod_sens_s2 <= prod_sens_c;
			prod_sq_s2   <= prod_sq_c;
		end
	end

	// Stage 3: shift down (arithmetic, rounds down) and add the base terms
	always_comb begin
		a_c    = prod_temp_s2[40:23];
		temp_c = 19'(a_c) + TEMP_REF;
		b_c    = 19'(a_c) + COLD_DEEP_OFS;
		off_c  = $signed({3'b000, cal.pressure_offset, 16'h0000})
			+ 35'($signed(prod_off_s2[40:7]));
		sens_c = $signed({3'b000, cal.pressure_sens, 15'h0000})
			+ 34'($signed(prod_sens_s2[40:8]));
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			fo_s3.d1     <= d1_s2;
			fo_s3.temp   <= temp_c;
			fo_s3.off    <= off_c;
			fo_s3.sens   <= sens_c;
			fo_s3.t2     <= prod_sq_s2[47:31];
			fo_s3.a      <= a_c;
			fo_s3.b      <= b_c;
			fo_s3.cold   <= a_c[17];
			fo_s3.colder <= b_c[18];
		end
	end

	assign fo = fo_s3;

endmodule

`default_nettype wire

@@ rtl/bptc_second_order.sv @@
// Second-order correction stages (stages 4 to 6): T2, OFF2, SENS2 and subtraction.
// Depends on bptc_pkg.
`default_nettype none

module bptc_second_order (
	input  wire logic          clk,
	input  wire logic [2:0]    en,
	input  wire bptc_pkg::fo_t fo,
	output bptc_pkg::so_t      so
);
	import bptc_pkg::*;

	logic [RAW_W-1:0]   d1_s4, d1_s5;
	logic signed [18:0] temp_s4;
	logic signed [34:0] off_s4, off_s5;
	logic signed [33:0] sens_s4, sens_s5;
	logic [16:0]        t2_s4;
	logic [34:0]        aa_s4, bb_s4;
	logic signed [35:0] aa_c;
	logic signed [37:0] bb_c;

	logic [36:0]        five_aa_c;
	logic [37:0]        eleven_bb_c;
	logic [37:0]        off2_c, off2_s5;
	logic [36:0]        sens2_c, sens2_s5;
	logic signed [19:0] temp_s5;
	so_t                so_s6;

	// Stage 4: squares of the distances below the thresholds
	always_comb begin
		aa_c = 36'(fo.a) * 36'(fo.a);
		bb_c = 38'(fo.b) * 38'(fo.b);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s4   <= fo.d1;
			temp_s4 <= fo.temp;
			off_s4  <= fo.off;
			sens_s4 <= fo.sens;
			// drop the corrections above the thresholds
			t2_s4   <= fo.cold ? fo.t2 : '0;
			aa_s4   <= fo.cold ? aa_c[34:0] : '0;
			bb_s4   <= fo.colder ? bb_c[34:0] : '0;
		end
	end

	// Stage 5: scale the squares into OFF2 and SENS2, subtract T2
	always_comb begin
		five_aa_c   = 37'(aa_s4) + {aa_s4, 2'b00};
		eleven_bb_c = {bb_s4, 3'b000} + 38'({bb_s4, 1'b0}) + 38'(bb_s4);
		off2_c  = 38'(five_aa_c[36:1]) + {bb_s4, 3'b000} - 38'(bb_s4);
		sens2_c = 37'(five_aa_c[36:2]) + eleven_bb_c[37:1];
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d1_s5    <= d1_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			temp_s5  <= 20'(temp_s4) - $signed({3'b000, t2_s4});
		end
	end

	// Stage 6: apply OFF2 and SENS2
	always_ff @(posedge clk) begin
		if (en[2]) begin
			so_s6.d1   <= d1_s5;
			so_s6.temp <= temp_s5;
			so_s6.off  <= 39'(off_s5) - $signed({1'b0, off2_s5});
			so_s6.sens <= 38'(sens_s5) - $signed({1'b0, sens2_s5});
		end
	end

	assign so = so_s6;

endmodule

`default_nettype wire

@@ rtl/bptc_pressure.sv @@
// Pressure stages (stages 7 to 10): split D1*SENS product, offset, saturation.
// Depends on bptc_pkg.
`default_nettype none

module bptc_pressure (
	input  wire logic          clk,
	input  wire logic [3:0]    en,
	input  wire bptc_pkg::so_t so,
	output bptc_pkg::res_t     res
);
	import bptc_pkg::*;

	logic [42:0]        lo_s7;
	logic signed [42:0] hi_s7;
	logic signed [38:0] off_s7, off_s8;
	logic signed [19:0] temp_s7, temp_s8, temp_s9;
	logic signed [61:0] prod_s8;
	logic signed [41:0] diff_c;
	logic signed [26:0] p_s9;
	res_t               res_c, res_s10;

	// Stage 7: partial products on the low and high halves of SENS
	always_ff @(posedge clk) begin
		if (en[0]) begin
			lo_s7   <= 43'(so.d1) * 43'(so.sens[18:0]);
			hi_s7   <= 43'($signed({1'b0, so.d1})) * 43'($signed(so.sens[37:19]));
			off_s7  <= so.off;
			temp_s7 <= so.temp;
		end
	end

	// Stage 8: combine the partial products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s8 <= $signed({hi_s7, 19'h00000}) + $signed({19'h00000, lo_s7});
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// Stage 9: shift down, subtract OFF, shift down again
	assign diff_c = 42'($signed(prod_s8[61:21])) - 42'(off_s8);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			p_s9    <= diff_c[41:15];
			temp_s9 <= temp_s8;
		end
	end

	// Stage 10: saturate both results and flag clipping
	always_comb begin
		res_c.clipped = 1'b0;
		if (p_s9 < 0) begin
			res_c.pressure = '0;
			res_c.clipped  = 1'b1;
		end else if (p_s9 > 27'sd262143) begin
			res_c.pressure = PRES_MAX;
			res_c.clipped  = 1'b1;
		end else begin
			res_c.pressure = p_s9[PRES_W-1:0];
		end
		if (temp_s9 < TEMP_MIN) begin
			res_c.temperature = TEMP_MIN[TEMP_OUT_W-1:0];
			res_c.clipped     = 1'b1;
		end else if (temp_s9 > TEMP_MAX) begin
			res_c.temperature = TEMP_MAX[TEMP_OUT_W-1:0];
			res_c.clipped     = 1'b1;
		end else begin
			res_c.temperature = temp_s9[TEMP_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			res_s10 <= res_c;
		end
	end

	assign res = res_s10;

endmodule

`default_nettype wire

@@ rtl/baro_pressure_temp_compensation.sv @@
// Top level of the barometric pressure and temperature compensation block.
// Depends on bptc_pkg, bptc_first_order, bptc_second_order, bptc_pressure.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   s_*     | in        | s_tvalid/s_tready  | raw pressure, raw temperature
//   m_*     | out       | m_tvalid/m_tready  | pressure, temperature; clipped
//   cfg_*   | in        | cfg_we             | calibration word by index
//
// One item per cycle while m_tready is high. The datapath has one register
// per stage: three first-order stages, three correction stages, four pressure stages
// with the D1*SENS product split over two.
// Reset clears the calibration words and all stage valid bits.
// Each stage takes a new item when it is empty or its successor advances, so
// a stall on m_tready fills bubbles first and loses nothing.
`default_nettype none

module baro_pressure_temp_compensation (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [bptc_pkg::S_DATA_W-1:0]       s_tdata,  // raw_pressure, raw_temperature
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [bptc_pkg::M_DATA_W-1:0]            m_tdata,  // pressure_centi_mbar, temperature_centi_c, zero pad
	output logic                                     m_tuser,  // clipped
	input  wire logic                                cfg_we,
	input  wire logic [bptc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bptc_pkg::CAL_W-1:0]          cfg_wdata
);
	import bptc_pkg::*;

	cal_t                  cal_q;
	logic [NUM_STAGES:1]   valid_q;
	logic [NUM_STAGES+1:1] adv;
	fo_t                   fo;
	so_t                   so;
	res_t                  res;

	// Write the calibration words; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (cal_idx_t'(cfg_index))
				CAL_PRESSURE_SENS:   cal_q.pressure_sens   <= cfg_wdata;
				CAL_PRESSURE_OFFSET: cal_q.pressure_offset <= cfg_wdata;
				CAL_SENS_TEMPCO:     cal_q.sens_tempco     <= cfg_wdata;
				CAL_OFFSET_TEMPCO:   cal_q.offset_tempco   <= cfg_wdata;
				CAL_REF_TEMP:        cal_q.ref_temp        <= cfg_wdata;
				CAL_TEMP_COEFF:      cal_q.temp_coeff      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		adv[NUM_STAGES+1] = m_tready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[1]) begin
				valid_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign s_tready = adv[1];

	bptc_first_order u_first_order (
		.clk             (clk),
		.en              (adv[3:1]),
		.cal             (cal_q),
		.raw_pressure    (s_tdata[RAW_W-1:0]),
		.raw_temperature (s_tdata[2*RAW_W-1:RAW_W]),
		.fo              (fo)
	);

	bptc_second_order u_second_order (
		.clk (clk),
		.en  (adv[6:4]),
		.fo  (fo),
		.so  (so)
	);

	bptc_pressure u_pressure (
		.clk (clk),
		.en  (adv[10:7]),
		.so  (so),
		.res (res)
	);

	// Drive the result channel from the last stage
	assign m_tvalid = valid_q[NUM_STAGES];
	assign m_tdata  = {{(M_DATA_W-PRES_W-TEMP_OUT_W){1'b0}}, res.temperature, res.pressure};
	assign m_tuser  = res.clipped;

endmodule

`default_nettype wire

@@ rtl/bptc_checker.sv @@
// Port-level checks for the compensation block, bound to its top level.
// Depends on baro_pressure_temp_compensation.
`default_nettype none

module bptc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [47:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tuser
);

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	// Flag clipping only when a field sits on a bound
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[17:0] == 18'h00000 || m_tdata[17:0] == 18'h3FFFF
			|| m_tdata[33:18] == 16'h8000 || m_tdata[33:18] == 16'h7FFF)
		else $error("clipped set with no saturated field");

	// Accept input whenever the output stage is empty
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

	// Show no result in the cycle after reset is seen
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the barometric pressure and temperature compensator.
// Predicts each reading in 64-bit integer math and compares it per field.
// Depends on bptc_pkg and baro_pressure_temp_compensation.

module tb;

	import bptc_pkg::*;

	// Raw conversion pair, packed as on s_tdata (pressure in the low bits)
	typedef struct packed {
		logic [RAW_W-1:0] raw_temperature;
		logic [RAW_W-1:0] raw_pressure;
	} sample_t;

	localparam int          STALL_LIMIT   = 2000;
	localparam int          RANDOM_PHASES = 10;
	localparam int          PHASE_ITEMS   = 128;
	localparam logic [23:0] RAW_MAX       = 24'hFFFFFF;
	localparam logic [23:0] NOMINAL_D1    = 24'd9085466;
	localparam longint      ROOM_TEMP     = 2000;
	localparam longint      DEEP_COLD     = -1500;
	localparam longint      PRES_TOP      = 262143;
	localparam longint      TEMP_LO       = -32768;
	localparam longint      TEMP_HI       = 32767;

	// Indexes past the last register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

	// Cal set mode for the random phases
	localparam int CAL_NEAR_NOMINAL = 0;
	localparam int CAL_ANY          = 1;
	localparam int CAL_RAILS        = 2;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata   = '0;  // raw_pressure, raw_temperature
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;         // pressure_centi_mbar, temperature_centi_c, zero pad
	logic                 m_tuser;         // clipped
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CAL_W-1:0]     cfg_wdata = '0;

	logic [CAL_W-1:0] cal_word [6];     // bench copy of the calibration registers
	logic [CAL_W-1:0] cal_plan [6];     // words for the next programming pass
	logic [CAL_W-1:0] nominal_cal [6];
	sample_t          pending_samples [$];
	res_t             expected_readings [$];
	res_t             want;
	int               failures     = 0;
	int               idle_pct     = 0;
	int               src_gap      = 0;
	int               sink_gap     = 0;
	int               stall_cycles = 0;

	baro_pressure_temp_compensation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Compensated reading for one raw pair under the current calibration
	function automatic res_t compensate(input sample_t smp);
		longint d1, d2, sens_c, off_c, sens_tc, off_tc, ref_c, temp_c;
		longint dt, tc, off, sens, t2, off2, sens2, a, b, p;
		res_t   r;
		d1      = {40'd0, smp.raw_pressure};
		d2      = {40'd0, smp.raw_temperature};
		sens_c  = {48'd0, cal_word[CAL_PRESSURE_SENS]};
		off_c   = {48'd0, cal_word[CAL_PRESSURE_OFFSET]};
		sens_tc = {48'd0, cal_word[CAL_SENS_TEMPCO]};
		off_tc  = {48'd0, cal_word[CAL_OFFSET_TEMPCO]};
		ref_c   = {48'd0, cal_word[CAL_REF_TEMP]};
		temp_c  = {48'd0, cal_word[CAL_TEMP_COEFF]};

		// First order; >>> on signed 64-bit rounds toward minus infinity
		dt   = d2 - ref_c * 256;
		tc   = ROOM_TEMP + ((dt * temp_c) >>> 23);
		off  = off_c * 65536 + ((off_tc * dt) >>> 7);
		sens = sens_c * 32768 + ((sens_tc * dt) >>> 8);

		// Second order below room temperature, taken from the first-order TEMP
		t2    = 0;
		off2  = 0;
		sens2 = 0;
		if (tc < ROOM_TEMP) begin
			a     = tc - ROOM_TEMP;
			t2    = (dt * dt) >>> 31;
			off2  = (5 * a * a) >>> 1;
			sens2 = (5 * a * a) >>> 2;
			if (tc < DEEP_COLD) begin
				b     = tc - DEEP_COLD;
				off2  = off2 + 7 * b * b;
				sens2 = sens2 + ((11 * b * b) >>> 1);
			end
		end
		tc   = tc - t2;
		off  = off - off2;
		sens = sens - sens2;
		p    = (((d1 * sens) >>> 21) - off) >>> 15;

		// Saturate both results
		r.clipped = 1'b0;
		if (p < 0) begin
			p = 0;
			r.clipped = 1'b1;
		end else if (p > PRES_TOP) begin
			p = PRES_TOP;
			r.clipped = 1'b1;
		end
		if (tc < TEMP_LO) begin
			tc = TEMP_LO;
			r.clipped = 1'b1;
		end else if (tc > TEMP_HI) begin
			tc = TEMP_HI;
			r.clipped = 1'b1;
		end
		r.pressure    = p[PRES_W-1:0];
		r.temperature = tc[TEMP_OUT_W-1:0];
		return r;
	endfunction

	// Random raw pair; mostly plausible pressure and a temperature spread
	// around the reference so all temperature bands get hit
	function automatic sample_t random_sample();
		sample_t s;
		longint  t, mag;
		int      k;
		s.raw_pressure    = 24'($urandom_range(0, RAW_MAX));
		s.raw_temperature = 24'($urandom_range(0, RAW_MAX));
		case ($urandom_range(0, 9))
			0, 1: begin
			end
			2: begin
				s.raw_pressure    = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
				s.raw_temperature = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
			end
			default: begin
				if ($urandom_range(0, 2) != 0) begin
					mag = {32'd0, $urandom} & 64'h3FFFFF;
					s.raw_pressure = $urandom_range(0, 1) ? NOMINAL_D1 + mag[23:0]
					                                     : NOMINAL_D1 - mag[23:0];
				end
				k   = $urandom_range(0, 24);
				mag = {32'd0, $urandom} & ((64'd1 << k) - 1);
				if ($urandom_range(0, 1))
					mag = -mag;
				t = {48'd0, cal_word[CAL_REF_TEMP]} * 256 + mag;
				if (t < 0)
					t = 0;
				else if (t > longint'(RAW_MAX))
					t = longint'(RAW_MAX);
				s.raw_temperature = t[RAW_W-1:0];
			end
		endcase
		return s;
	endfunction

	function automatic logic [CAL_W-1:0] pick_cal(input int mode, input logic [CAL_W-1:0] base);
		case (mode)
			CAL_NEAR_NOMINAL: return base + 16'($urandom_range(0, 8191)) - 16'd4096;
			CAL_ANY:          return 16'($urandom_range(0, 65535));
			default:          return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	// Write all six registers from cal_plan, then poke both spare indexes
	task automatic program_cal();
		for (int i = CAL_PRESSURE_SENS; i <= CAL_TEMP_COEFF; i++) begin
			@(posedge clk);
			cfg_we      <= 1'b1;
			cfg_index   <= i[CFG_IDX_W-1:0];
			cfg_wdata   <= cal_plan[i];
			cal_word[i] = cal_plan[i];
		end
		@(posedge clk);
		cfg_index <= CFG_IDX_SPARE_LO;
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
		cfg_index <= CFG_IDX_SPARE_HI;
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_sample(input logic [23:0] rp, input logic [23:0] rt);
		sample_t s;
		s.raw_pressure    = rp;
		s.raw_temperature = rt;
		pending_samples.push_back(s);
	endtask

	// Hold until every item is through, then let the pipeline settle
	task automatic drain();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || expected_readings.size() != 0 || s_tvalid);
		repeat (NUM_STAGES + 2) @(posedge clk);
	endtask

	// Source side: present queued items, idle in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_readings.push_back(compensate(sample_t'(s_tdata)));
			if (s_tvalid && !s_tready) begin
				// hold the item until taken
			end else if (src_gap > 0) begin
				src_gap  <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				src_gap  <= $urandom_range(0, 14);
				s_tvalid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				s_tdata  <= pending_samples.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink side: check each reading, stall in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected reading: pressure %0d temperature %0d clipped %0b",
					         $time, m_tdata[0 +: PRES_W],
					         $signed(m_tdata[PRES_W +: TEMP_OUT_W]), m_tuser);
					failures++;
				end else begin
					want = expected_readings.pop_front();
					if (m_tdata[0 +: PRES_W] !== want.pressure) begin
						$display("%0t: pressure mismatch: expected %0d actual %0d",
						         $time, want.pressure, m_tdata[0 +: PRES_W]);
						failures++;
					end
					if (m_tdata[PRES_W +: TEMP_OUT_W] !== want.temperature) begin
						$display("%0t: temperature mismatch: expected %0d actual %0d",
						         $time, want.temperature, $signed(m_tdata[PRES_W +: TEMP_OUT_W]));
						failures++;
					end
					if (m_tuser !== want.clipped) begin
						$display("%0t: clipped mismatch: expected %0b actual %0b",
						         $time, want.clipped, m_tuser);
						failures++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				sink_gap <= $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		for (int i = CAL_PRESSURE_SENS; i <= CAL_TEMP_COEFF; i++)
			cal_word[i] = '0;
		// pressure sens, pressure offset, sens tempco, offset tempco, ref temp, temp coeff
		nominal_cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Uncalibrated block: all registers still zero
		@(negedge clk);
		idle_pct = 20;
		queue_sample(24'd0, 24'd0);
		queue_sample(RAW_MAX, RAW_MAX);
		queue_sample(RAW_MAX, 24'd0);
		queue_sample(24'd0, RAW_MAX);
		drain();

		// Nominal calibration: room, cold, deep cold, hot, pressure below range
		cal_plan = nominal_cal;
		program_cal();
		@(negedge clk);
		queue_sample(NOMINAL_D1, 24'd8569150);
		queue_sample(NOMINAL_D1, 24'd8566784 - 24'd600000);
		queue_sample(NOMINAL_D1, 24'd8566784 - 24'd2000000);
		queue_sample(NOMINAL_D1, 24'd8566784 + 24'd3000000);
		queue_sample(24'd0, 24'd8569150);
		queue_sample(RAW_MAX, 24'd8569150);
		drain();

		// All registers at full scale: pressure above range, temperature below
		foreach (cal_plan[i])
			cal_plan[i] = 16'hFFFF;
		program_cal();
		@(negedge clk);
		queue_sample(RAW_MAX, RAW_MAX);
		queue_sample(24'd0, 24'd0);
		queue_sample(RAW_MAX, 24'd0);
		queue_sample(24'd0, RAW_MAX);
		queue_sample(24'h800000, 24'h800000);
		drain();

		// Zero reference with steep slope: temperature above range
		cal_plan = '{16'd20000, 16'd30000, 16'd20000, 16'd20000, 16'd0, 16'hFFFF};
		program_cal();
		@(negedge clk);
		queue_sample(NOMINAL_D1, RAW_MAX);
		queue_sample(NOMINAL_D1, 24'd0);
		queue_sample(RAW_MAX, 24'h400000);
		drain();

		// Random phases, each under a fresh calibration; the last two run flat out
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			foreach (cal_plan[i])
				cal_plan[i] = pick_cal(ph % 3, nominal_cal[i]);
			program_cal();
			@(negedge clk);
			if (ph >= RANDOM_PHASES - 2)
				idle_pct = 0;
			else
				idle_pct = (ph % 2 == 0) ? 8 : 35;
			for (int n = 0; n < PHASE_ITEMS; n++)
				pending_samples.push_back(random_sample());
			drain();
		end

		repeat (2 * NUM_STAGES) @(posedge clk);
		if (failures == 0 && expected_readings.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
